>>> rtl/core/cft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cft_pkg
// Shared types and constants for the constant fraction timing unit.
// ----------------------------------------------------------------------------
package cft_pkg;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_EDGE = 2'd2;
  localparam logic [1:0] ST_FLAT = 2'd3;

  localparam logic REG_FRAC   = 1'b0;
  localparam logic REG_INVERT = 1'b1;

  localparam int unsigned CT_W = 20;
  localparam logic [CT_W-1:0] CT_MAX = '1;

  // result word fields
  typedef struct packed {
    logic [1:0]         status;
    logic signed [16:0] slope;
    logic signed [15:0] baseline;
    logic signed [16:0] amplitude;
    logic [CT_W-1:0]    cross_time;
  } result_t;

endpackage

>>> rtl/core/cft_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cft_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module cft_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/core/cft_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cft_div
// Shared restoring divider for unsigned magnitudes, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module cft_div #(
  parameter int NW = 48,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic          rem_nz
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q;
  logic [DW:0]   rem;
  logic [DW-1:0] d;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  assign trial = {rem[DW-1:0], q[NW-1]};
  assign diff  = trial - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q    <= num;
        d    <= den;
        rem  <= '0;
        cnt  <= CW'(NW);
      end else if (busy) begin
        if (!diff[DW]) begin
          rem <= diff;
          q   <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo    = q;
  assign rem_nz = (rem != '0);

endmodule

>>> rtl/core/constant_fraction_timing_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// constant_fraction_timing_unit
// Constant fraction timing of one negative pulse waveform.
//
// Input words on s_axis (sample in tdata, end of waveform on tlast) are
// taken one per cycle and written into a waveform RAM while the peak and
// the baseline sum are tracked. The word with tlast starts the analysis:
// baseline divide, a back scan from the peak that reads one RAM sample
// and checks it before the next is read, three neighbor reads, then a
// divide for the crossing time. One result word leaves on m_axis; s_axis
// is not ready from the last sample until that word is taken, so a
// stalled receiver holds the block.
// The cfg channel writes frac_percent (index 0) and invert_polarity
// (index 1) and is always ready. Reset (rst, synchronous) clears the
// waveform state and sets frac_percent 40, invert_polarity 0; the RAM is
// not cleared, only entries written in the current waveform are read.
// ----------------------------------------------------------------------------
module constant_fraction_timing_unit #(
  parameter int WAVE_LEN  = 2048,
  parameter int BASE_LEN  = 100,
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // cross_time, amplitude, baseline, slope, status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int AW = $clog2(WAVE_LEN);
  localparam int NCW = $clog2(WAVE_LEN + 1);
  localparam int BW = $clog2(BASE_LEN + 1);
  localparam int SW = 16 + BW;
  localparam int NW = 48;
  localparam int DW = 32;

  typedef enum logic [3:0] {
    S_RECV, S_BDIV, S_BWAIT, S_SCAN, S_SRD, S_SCHK, S_R1, S_R2, S_R3, S_R3W,
    S_FIT, S_FWAIT, S_OUT
  } state_t;

  state_t state;
  logic [6:0]  frac_percent;
  logic        invert_polarity;
  logic [NCW-1:0] sample_count;
  logic signed [15:0] peak_value;
  logic [AW-1:0] peak_index;
  logic          peak_found;
  logic signed [SW-1:0] base_sum;
  logic signed [15:0] base;
  logic signed [16:0] amp;
  logic [6:0]  frac;
  logic signed [24:0] thr;
  logic [AW:0] idx;
  logic [AW-1:0] r;
  logic signed [16:0] y1, y2;
  logic        num_neg;
  logic        den_neg;
  logic signed [16:0] y3v;
  cft_pkg::result_t res;

  logic        ram_we;
  logic [AW-1:0] ram_addr;
  logic [15:0] ram_wdata, ram_rdata;

  logic        div_start, div_done, div_rnz;
  logic [NW-1:0] div_num, div_quo;
  logic [DW-1:0] div_den;

  logic signed [15:0] s_in;
  logic in_acc;
  logic signed [16:0] y_rd;
  logic signed [31:0] y_x100;
  logic [BW-1:0] cnt;
  logic signed [16:0] amp_c;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_RECV);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {8'd0, res};

  always_comb begin
    s_in = s_axis_tdata;
    if (invert_polarity) begin
      s_in = (s_axis_tdata == 16'sh8000) ? 16'sh7fff : -$signed(s_axis_tdata);
    end
  end

  assign y_rd   = 17'($signed(ram_rdata)) - 17'(base);
  assign y_x100 = 32'(y_rd) * 32'sd100;
  assign cnt    = (sample_count < NCW'(BASE_LEN)) ? BW'(sample_count) : BW'(BASE_LEN);
  assign amp_c  = 17'(peak_value) - 17'(base);

  cft_ram #(.WIDTH(16), .DEPTH(WAVE_LEN)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  cft_div #(.NW(NW), .DW(DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo), .rem_nz(div_rnz)
  );

  always_comb begin
    ram_we    = in_acc && (sample_count < NCW'(WAVE_LEN));
    ram_wdata = s_in;
    ram_addr  = sample_count[AW-1:0];
    case (state)
      S_SRD, S_SCHK: ram_addr = idx[AW-1:0];
      S_R1:          ram_addr = r - 1'b1;
      S_R2:          ram_addr = r;
      S_R3:          ram_addr = r + 1'b1;
      default:       ;
    endcase
  end

  // fit terms
  logic signed [31:0] s3;
  logic signed [31:0] fnum;
  logic signed [31:0] fden;
  assign s3   = 32'(y1) + 32'(y2) + 32'(y_rd);
  assign fnum = 32'sd6 * 32'(thr) - 32'sd200 * s3;
  assign fden = 32'sd300 * (32'(y_rd) - 32'(y1));

  logic signed [NW:0] q_s;
  logic signed [NW+1:0] ct_full;
  always_comb begin
    q_s = (num_neg != den_neg) ? -$signed({1'b0, div_quo}) - (NW+1)'(div_rnz)
                               : $signed({1'b0, div_quo});
    ct_full = ((NW+2)'(r) <<< FRAC_BITS) + (NW+2)'(q_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_RECV;
      frac_percent    <= 7'd40;
      invert_polarity <= 1'b0;
      sample_count    <= '0;
      peak_value      <= '0;
      peak_index      <= '0;
      peak_found      <= 1'b0;
      base_sum        <= '0;
      div_start       <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_valid) begin
        if (cfg_index == cft_pkg::REG_FRAC) frac_percent <= cfg_data;
        else invert_polarity <= cfg_data[0];
      end
      case (state)
        S_RECV: begin
          if (in_acc) begin
            if (sample_count < NCW'(WAVE_LEN)) begin
              if (s_in < peak_value) begin
                peak_value <= s_in;
                peak_index <= sample_count[AW-1:0];
                peak_found <= 1'b1;
              end
              if (sample_count < NCW'(BASE_LEN)) base_sum <= base_sum + SW'(s_in);
              sample_count <= sample_count + 1'b1;
            end
            if (s_axis_tlast) state <= S_BDIV;
          end
        end
        S_BDIV: begin
          frac <= (frac_percent > 7'd100) ? 7'd100 : frac_percent;
          if (cnt == '0) begin
            base  <= '0;
            state <= S_BWAIT;
          end else begin
            num_neg   <= base_sum[SW-1];
            den_neg   <= 1'b0;
            div_num   <= NW'(base_sum[SW-1] ? -base_sum : base_sum);
            div_den   <= DW'(cnt);
            div_start <= 1'b1;
            state     <= S_BWAIT;
          end
        end
        S_BWAIT: begin
          if (cnt == '0 || div_done) begin
            if (cnt != '0) begin
              base <= 16'(num_neg ? -$signed({1'b0, div_quo}) - (NW+1)'(div_rnz)
                                  : $signed({1'b0, div_quo}));
            end
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          amp <= amp_c;
          thr <= $signed(25'(amp_c)) * $signed(25'(frac));
          if (!peak_found || amp_c >= 0) begin
            res.status     <= cft_pkg::ST_NONE;
            res.cross_time <= '0;
            res.slope      <= '0;
            res.amplitude  <= amp_c;
            res.baseline   <= base;
            state          <= S_OUT;
          end else begin
            idx   <= (AW+1)'(peak_index);
            r     <= peak_index;
            state <= S_SRD;
          end
        end
        S_SRD: begin
          state <= S_SCHK;
        end
        S_SCHK: begin
          // ram_rdata holds sample idx (read issued last cycle)
          if (32'(y_x100) > 32'(thr)) begin
            state <= S_R1;
          end else begin
            r <= idx[AW-1:0];
            if (idx == '0) state <= S_R1;
            else begin
              idx   <= idx - 1'b1;
              state <= S_SRD;
            end
          end
        end
        S_R1: begin
          res.amplitude <= amp;
          res.baseline  <= base;
          res.slope     <= '0;
          if (r == '0 || (NCW'(r) + 1'b1) >= sample_count) begin
            res.status     <= cft_pkg::ST_EDGE;
            res.cross_time <= cft_pkg::CT_W'(r) << FRAC_BITS;
            state          <= S_OUT;
          end else begin
            state <= S_R2;
          end
        end
        S_R2: begin
          y1    <= y_rd;
          state <= S_R3;
        end
        S_R3: begin
          y2    <= y_rd;
          state <= S_R3W;
        end
        S_R3W: begin
          y3v   <= y_rd;
          state <= S_FIT;
          if (y_rd == y1) begin
            res.status     <= cft_pkg::ST_FLAT;
            res.cross_time <= cft_pkg::CT_W'(r) << FRAC_BITS;
            state          <= S_OUT;
          end else begin
            num_neg  <= fnum[31];
            den_neg  <= fden[31];
            div_num  <= NW'(fnum[31] ? -fnum : fnum) << FRAC_BITS;
            div_den  <= DW'(fden[31] ? -fden : fden);
          end
        end
        S_FIT: begin
          div_start <= 1'b1;
          res.slope <= 17'((18'(y3v) - 18'(y1)) >>> 1);
          state     <= S_FWAIT;
        end
        S_FWAIT: begin
          if (div_done) begin
            res.status <= cft_pkg::ST_OK;
            if (ct_full < 0) res.cross_time <= '0;
            else if (ct_full > (NW+2)'(cft_pkg::CT_MAX)) res.cross_time <= cft_pkg::CT_MAX;
            else res.cross_time <= cft_pkg::CT_W'(ct_full);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            sample_count <= '0;
            peak_value   <= '0;
            peak_index   <= '0;
            peak_found   <= 1'b0;
            base_sum     <= '0;
            state        <= S_RECV;
          end
        end
        default: state <= S_RECV;
      endcase
    end
  end

endmodule
